@@ sv/cpt_pkg.sv @@
`timescale 1ns / 1ps

package cpt_pkg;

    localparam int MinWidth   = 7;
    localparam int DebWidth   = 8;
    localparam int PhaseWidth = 13;
    localparam int SegWidth   = 7;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 13;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_INITIAL_MINUTES   = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE_TICKS    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_PHASES_PER_MINUTE = 2'd2;

    // run modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_SHOW  = 2'd1;
    localparam logic [1:0] MODE_LOCK  = 2'd2;
    localparam logic [1:0] MODE_WAIT  = 2'd3;

    localparam logic [SegWidth-1:0] SEG_DARK = 7'h7F;

    localparam logic [MinWidth-1:0]   RST_INITIAL_MINUTES   = 7'd10;
    localparam logic [DebWidth-1:0]   RST_DEBOUNCE_TICKS    = 8'd20;
    localparam logic [PhaseWidth-1:0] RST_PHASES_PER_MINUTE = 13'd6000;

    typedef struct packed {
        logic [SegWidth-1:0] segment_lines;
        logic                tens_enable;
        logic                ones_enable;
        logic                power_on;
    } t_result;

    // active-low segment patterns for digits 0..9
    function automatic logic [SegWidth-1:0] seg_pattern(input logic [3:0] digit);
        logic [SegWidth-1:0] pat;
        begin
            case (digit)
                4'd0: pat = 7'h40;
                4'd1: pat = 7'h67;
                4'd2: pat = 7'h12;
                4'd3: pat = 7'h03;
                4'd4: pat = 7'h25;
                4'd5: pat = 7'h09;
                4'd6: pat = 7'h08;
                4'd7: pat = 7'h63;
                4'd8: pat = 7'h00;
                4'd9: pat = 7'h01;
                default: pat = SEG_DARK;
            endcase
            return pat;
        end
    endfunction

endpackage

@@ sv/cpt_core.sv @@
`timescale 1ns / 1ps

module cpt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_write,
    input  logic [cpt_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [cpt_pkg::CfgDataWidth-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_button_level,
    input  logic                          i_restart_pulse,
    output cpt_pkg::t_result              o_result
);
    import cpt_pkg::*;

    logic [MinWidth-1:0]   r_initial_minutes;
    logic [DebWidth-1:0]   r_debounce_ticks;
    logic [PhaseWidth-1:0] r_phases_per_minute;

    logic [MinWidth-1:0]   r_minutes_left,  n_minutes_left;
    logic [PhaseWidth-1:0] r_phase_index,   n_phase_index;
    logic [1:0]            r_run_mode,      n_run_mode;
    logic [DebWidth-1:0]   r_lockout_count, n_lockout_count;
    logic                  r_restart,       n_restart;
    logic [SegWidth-1:0]   r_segment_latch, n_segment_latch;

    logic                  restart_now;
    logic                  min_zero;
    logic                  is_show;
    logic                  start_show;
    logic [MinWidth-1:0]   show_min;
    logic [PhaseWidth-1:0] show_phase;
    logic                  show_restart;
    logic [14:0]           tens_prod;
    logic [3:0]            tens;
    logic [3:0]            ones;
    logic [6:0]            tens_x10;
    logic [PhaseWidth:0]   phase_next;
    logic                  minute_end;
    logic                  lock_enter;
    logic [MinWidth-1:0]   lock_min;
    logic [DebWidth-1:0]   lock_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_minutes   <= RST_INITIAL_MINUTES;
            r_debounce_ticks    <= RST_DEBOUNCE_TICKS;
            r_phases_per_minute <= RST_PHASES_PER_MINUTE;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_INITIAL_MINUTES:   r_initial_minutes   <= i_cfg_data[MinWidth-1:0];
                CFG_DEBOUNCE_TICKS:    r_debounce_ticks    <= i_cfg_data[DebWidth-1:0];
                CFG_PHASES_PER_MINUTE: r_phases_per_minute <= i_cfg_data[PhaseWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        restart_now = r_restart | i_restart_pulse;
        min_zero    = (r_minutes_left == '0);
        start_show  = (r_run_mode == MODE_START) && !min_zero && !i_button_level;
        is_show     = (r_run_mode == MODE_SHOW) || start_show;

        // a running minute start consumes the latched restart and reloads
        show_min     = (start_show && restart_now) ? r_initial_minutes : r_minutes_left;
        show_phase   = start_show ? '0 : r_phase_index;
        show_restart = start_show ? 1'b0 : restart_now;

        // tens = m / 10 through the reciprocal 205 / 2048, exact below 1029
        tens_prod = 15'(show_min) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        ones      = 4'(show_min - tens_x10);

        phase_next = {1'b0, show_phase} + 14'd1;
        minute_end = show_restart || (phase_next >= {1'b0, r_phases_per_minute});

        lock_enter = (r_run_mode == MODE_START) && i_button_level;
        lock_min   = min_zero ? r_initial_minutes : '0;
        lock_dec   = (r_lockout_count != '0) ? r_lockout_count - 8'd1 : r_lockout_count;

        n_minutes_left  = r_minutes_left;
        n_phase_index   = r_phase_index;
        n_run_mode      = r_run_mode;
        n_lockout_count = r_lockout_count;
        n_restart       = restart_now;
        n_segment_latch = r_segment_latch;
        o_result.tens_enable = 1'b0;
        o_result.ones_enable = 1'b0;
        o_result.power_on    = 1'b0;

        if (is_show) begin
            o_result.power_on = 1'b1;
            if (start_show && restart_now) begin
                n_restart = 1'b0;
            end
            if (!show_phase[0]) begin
                if (tens != 4'd0) begin
                    if (tens <= 4'd9) begin
                        n_segment_latch = seg_pattern(tens);
                    end
                    o_result.tens_enable = 1'b1;
                end
            end else begin
                n_segment_latch      = seg_pattern(ones);
                o_result.ones_enable = 1'b1;
            end
            if (minute_end) begin
                n_minutes_left = (show_min != '0) ? show_min - 7'd1 : show_min;
                n_phase_index  = '0;
                n_run_mode     = MODE_START;
            end else begin
                n_minutes_left = show_min;
                n_phase_index  = phase_next[PhaseWidth-1:0];
                n_run_mode     = MODE_SHOW;
            end
        end else if (lock_enter) begin
            // press tick counts as the first lockout tick
            n_minutes_left    = lock_min;
            o_result.power_on = !min_zero;
            if (r_debounce_ticks <= 8'd1) begin
                n_lockout_count = '0;
                n_run_mode      = MODE_WAIT;
            end else begin
                n_lockout_count = r_debounce_ticks - 8'd1;
                n_run_mode      = MODE_LOCK;
            end
        end else if (r_run_mode == MODE_LOCK) begin
            o_result.power_on = min_zero;
            n_lockout_count   = lock_dec;
            if (lock_dec == '0) begin
                n_run_mode = MODE_WAIT;
            end
        end else if (r_run_mode == MODE_WAIT) begin
            o_result.power_on = min_zero;
            if (!i_button_level) begin
                n_run_mode = MODE_START;
            end
        end

        o_result.segment_lines = n_segment_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minutes_left  <= RST_INITIAL_MINUTES;
            r_phase_index   <= '0;
            r_run_mode      <= MODE_START;
            r_lockout_count <= '0;
            r_restart       <= 1'b0;
            r_segment_latch <= SEG_DARK;
        end else if (i_accept) begin
            r_minutes_left  <= n_minutes_left;
            r_phase_index   <= n_phase_index;
            r_run_mode      <= n_run_mode;
            r_lockout_count <= n_lockout_count;
            r_restart       <= n_restart;
            r_segment_latch <= n_segment_latch;
        end
    end

endmodule

@@ sv/cpt_skid.sv @@
`timescale 1ns / 1ps

module cpt_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  cpt_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_full,
    output logic             o_out_valid,
    output cpt_pkg::t_result o_result
);
    import cpt_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take        = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_accept;
            end
        end else if (i_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_accept) begin
            if (r_out_valid) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

endmodule

@@ sv/countdown_power_timer_display.sv @@
`timescale 1ns / 1ps

// Countdown power timer with a two-digit multiplexed seven-segment display.
// Each input word is one 10 ms tick (button level, restart pulse) and gives
// exactly one output word (segments, digit enables, power enable). A tick is
// handled as one step: the timer state updates at the accepting edge and the
// result word lands in a two-entry output buffer, so one tick per clock is
// taken as long as the output side keeps up; o_in_stall rises only when both
// buffer entries hold untaken words. Configuration writes are always ready
// and should be issued only while no tick is in flight.
module countdown_power_timer_display (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpt_pkg::CfgIdxWidth-1:0]   i_cfg_index,
    input  logic [cpt_pkg::CfgDataWidth-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_button_level,
    input  logic                              i_restart_pulse,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cpt_pkg::SegWidth-1:0]      o_segment_lines,
    output logic                              o_tens_enable,
    output logic                              o_ones_enable,
    output logic                              o_power_on
);
    import cpt_pkg::*;

    logic    accept;
    logic    full;
    t_result core_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    cpt_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_button_level  (i_button_level),
        .i_restart_pulse (i_restart_pulse),
        .o_result        (core_result)
    );

    cpt_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_result    (core_result),
        .i_out_stall (i_out_stall),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_segment_lines = out_result.segment_lines;
    assign o_tens_enable   = out_result.tens_enable;
    assign o_ones_enable   = out_result.ones_enable;
    assign o_power_on      = out_result.power_on;

endmodule

@@ sv/cpt_checker.sv @@
`timescale 1ns / 1ps

module cpt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [6:0] o_segment_lines,
    input logic       o_tens_enable,
    input logic       o_ones_enable,
    input logic       o_power_on
);

    // a stalled word stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its segments
    a_seg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_segment_lines))
        else $error("segments changed while stalled");

    // only one digit is driven at a time
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tens_enable && o_ones_enable))
        else $error("both digit enables driven");

    // digits are only multiplexed while the load is powered
    a_digit_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_tens_enable || o_ones_enable) |-> o_power_on)
        else $error("digit driven with power off");

endmodule

bind countdown_power_timer_display cpt_checker u_cpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_segment_lines (o_segment_lines),
    .o_tens_enable   (o_tens_enable),
    .o_ones_enable   (o_ones_enable),
    .o_power_on      (o_power_on)
);
